>>> rtl/sgm_pkg.sv
// Package for the 3x3 Sobel gradient magnitude block: widths, register indexes,
// reset sizes, window types and the gradient magnitude function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sgm_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4095;

  localparam int PIX_W    = 8;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 12;
  localparam int ROW_W    = 12;
  localparam int CFG_W    = 12;
  localparam int IDX_W    = 1;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

  typedef logic [2:0][PIX_W-1:0] win_row_t;
  typedef win_row_t [2:0] win_t;

  // Sobel |gx|+|gy| saturated to 255. The right column is always index 2; the left
  // column moves to index 1 at the left image edge, the center to index 2 at the right edge.
  function automatic logic [PIX_W-1:0] sobel_mag(input win_row_t t, input win_row_t m,
                                                 input win_row_t b, input logic left_edge,
                                                 input logic right_edge);
    logic [1:0] cl;
    logic [1:0] cc;
    logic [9:0] sum_r;
    logic [9:0] sum_l;
    logic [9:0] sum_b;
    logic [9:0] sum_t;
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic [10:0] ax;
    logic [10:0] ay;
    logic [11:0] s;
    cl = left_edge ? 2'd1 : 2'd0;
    cc = right_edge ? 2'd2 : 2'd1;
    sum_r = {2'b00, t[2]} + {1'b0, m[2], 1'b0} + {2'b00, b[2]};
    sum_l = {2'b00, t[cl]} + {1'b0, m[cl], 1'b0} + {2'b00, b[cl]};
    sum_b = {2'b00, b[cl]} + {1'b0, b[cc], 1'b0} + {2'b00, b[2]};
    sum_t = {2'b00, t[cl]} + {1'b0, t[cc], 1'b0} + {2'b00, t[2]};
    gx = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
    gy = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
    ax = gx[10] ? $unsigned(-gx) : $unsigned(gx);
    ay = gy[10] ? $unsigned(-gy) : $unsigned(gy);
    s = {1'b0, ax} + {1'b0, ay};
    return (s > 12'd255) ? 8'hFF : s[7:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/sgm_if.sv
// Handshake interfaces for the Sobel block: the pixel input channel and the
// result channel. Depends on sgm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sgm_pix_if;
  logic                     valid;
  logic                     ready;
  logic [sgm_pkg::PIX_W-1:0] pixel;

  modport source(output valid, output pixel, input ready);
  modport sink(input valid, input pixel, output ready);
endinterface

interface sgm_res_if #(
  parameter int COL_W = $clog2(sgm_pkg::MAX_WIDTH_DEF)
);
  logic                      valid;
  logic                      ready;
  logic [sgm_pkg::PIX_W-1:0] magnitude;
  logic [COL_W-1:0]          column;
  logic [sgm_pkg::ROW_W-1:0] row;
  logic                      frame_last;

  modport source(output valid, output magnitude, output column, output row,
                 output frame_last, input ready);
  modport sink(input valid, input magnitude, input column, input row,
               input frame_last, output ready);
endinterface

`default_nettype wire

>>> rtl/sobel_gradient_magnitude_3x3_top.sv
// Pixels are registered in the pixel stage; as it advances, their results fill the result
// slots that offer them. One pixel per cycle while each pixel completes at most one result
// and results are taken; a pixel with more (row ends, last row) holds the input until the
// single result word port takes them all. Reset clears counters, window and valid state and
// sets the size to 640x480; the two line memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sobel_gradient_magnitude_3x3_top #(
  parameter int MAX_WIDTH = sgm_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         write_enable,
  input  wire logic [sgm_pkg::IDX_W-1:0]    reg_index,
  input  wire logic [sgm_pkg::CFG_W-1:0]    write_data,
  sgm_pix_if.sink                           pixels,
  sgm_res_if.source                         results
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int EW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (EW > sgm_pkg::WIDTH_W) ? EW : sgm_pkg::WIDTH_W;
  localparam int RW   = sgm_pkg::ROW_W;
  localparam int PW   = sgm_pkg::PIX_W;

  localparam logic [1:0] SLOT_U1 = 2'd0;
  localparam logic [1:0] SLOT_U2 = 2'd1;
  localparam logic [1:0] SLOT_L1 = 2'd2;
  localparam logic [1:0] SLOT_L2 = 2'd3;

  logic [sgm_pkg::WIDTH_W-1:0]  image_width;
  logic [sgm_pkg::HEIGHT_W-1:0] image_height;

  logic [CMPW-1:0] width_ext;
  logic [CMPW-1:0] width_sat;
  logic [EW-1:0]   eff_w;
  logic [EW-1:0]   w_last;
  logic [RW-1:0]   eff_h;
  logic [RW-1:0]   h_last;

  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_count_next;
  logic [RW-1:0] row_count_next;
  logic          col_ge;
  logic [RW-1:0] row_inc;
  logic [CW-1:0] x_a;
  logic [RW-1:0] y_a;
  logic [EW-1:0] x_plus;
  logic [RW-1:0] y_plus;
  logic          col_wrap;
  logic          in_accept;

  logic [PW-1:0] upper_mem [MAX_WIDTH];
  logic [PW-1:0] middle_mem [MAX_WIDTH];
  logic [PW-1:0] rd_upper;
  logic [PW-1:0] rd_middle;

  logic          b_valid;
  logic [PW-1:0] b_px;
  logic [CW-1:0] b_x;
  logic [RW-1:0] b_y;
  logic          b_up;
  logic          b_low;
  logic          b_ytop;
  logic          b_left;
  logic          b_right;
  logic          b_adv;

  sgm_pkg::win_t     window;
  sgm_pkg::win_t     window_next;
  sgm_pkg::win_row_t top_u;

  logic [3:0]    res_mask;
  logic [3:0]    res_mask_next;
  logic [PW-1:0] res_mag [4];
  logic [CW-1:0] res_col [4];
  logic [RW-1:0] res_row [4];
  logic [1:0]    sel;
  logic          res_free;
  logic          out_accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sgm_pkg::WIDTH_RESET;
      image_height <= sgm_pkg::HEIGHT_RESET;
    end else if (write_enable) begin
      unique case (reg_index)
        sgm_pkg::REG_IMAGE_WIDTH:  image_width  <= write_data[sgm_pkg::WIDTH_W-1:0];
        sgm_pkg::REG_IMAGE_HEIGHT: image_height <= write_data[sgm_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    width_ext = CMPW'(image_width);
    if (width_ext < CMPW'(2)) begin
      width_sat = CMPW'(2);
    end else if (width_ext > CMPW'(MAX_WIDTH)) begin
      width_sat = CMPW'(MAX_WIDTH);
    end else begin
      width_sat = width_ext;
    end
    eff_w  = EW'(width_sat);
    w_last = eff_w - EW'(1);
    eff_h  = (image_height < RW'(2)) ? RW'(2) : image_height;
    h_last = eff_h - RW'(1);
  end

  // Position of the incoming pixel and the counters that follow it.
  always_comb begin
    col_ge   = EW'(col_count) >= eff_w;
    x_a      = col_ge ? '0 : col_count;
    row_inc  = col_ge ? row_count + RW'(1) : row_count;
    y_a      = (row_inc >= eff_h) ? '0 : row_inc;
    x_plus   = EW'(x_a) + EW'(1);
    y_plus   = y_a + RW'(1);
    col_wrap = x_plus >= eff_w;
    if (col_wrap) begin
      col_count_next = '0;
      row_count_next = (y_plus >= eff_h) ? '0 : y_plus;
    end else begin
      col_count_next = x_plus[CW-1:0];
      row_count_next = y_a;
    end
  end

  assign res_free      = (res_mask == 4'b0000) || ($onehot(res_mask) && results.ready);
  assign b_adv         = b_valid && (!b_up || res_free);
  assign pixels.ready  = !b_valid || b_adv;
  assign in_accept     = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_upper  <= upper_mem[x_a];
      rd_middle <= middle_mem[x_a];
    end
    if (b_adv) begin
      upper_mem[b_x]  <= rd_middle;
      middle_mem[b_x] <= b_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_accept) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      b_px    <= pixels.pixel;
      b_x     <= x_a;
      b_y     <= y_a;
      b_up    <= (x_a != '0) && (y_a != '0);
      b_low   <= (x_a != '0) && (y_a == h_last);
      b_ytop  <= y_a == RW'(1);
      b_left  <= x_a == CW'(1);
      b_right <= EW'(x_a) == w_last;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      window_next[r][0] = window[r][1];
      window_next[r][1] = window[r][2];
    end
    window_next[0][2] = rd_upper;
    window_next[1][2] = rd_middle;
    window_next[2][2] = b_px;
    top_u = b_ytop ? window_next[1] : window_next[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (b_adv) begin
      window <= window_next;
    end
  end

  always_comb begin
    if (res_mask[0]) begin
      sel = SLOT_U1;
    end else if (res_mask[1]) begin
      sel = SLOT_U2;
    end else if (res_mask[2]) begin
      sel = SLOT_L1;
    end else begin
      sel = SLOT_L2;
    end
  end

  assign out_accept = results.valid && results.ready;

  always_comb begin
    res_mask_next = res_mask;
    if (out_accept) begin
      res_mask_next = res_mask & ~(4'b0001 << sel);
    end
    if (b_adv && b_up) begin
      res_mask_next = {b_low && b_right, b_low, b_right, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_mask <= 4'b0000;
    end else begin
      res_mask <= res_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && b_up) begin
      res_mag[SLOT_U1] <= sgm_pkg::sobel_mag(top_u, window_next[1], window_next[2],
                                             b_left, 1'b0);
      res_mag[SLOT_U2] <= sgm_pkg::sobel_mag(top_u, window_next[1], window_next[2],
                                             1'b1, 1'b1);
      res_mag[SLOT_L1] <= sgm_pkg::sobel_mag(window_next[1], window_next[2], window_next[2],
                                             b_left, 1'b0);
      res_mag[SLOT_L2] <= sgm_pkg::sobel_mag(window_next[1], window_next[2], window_next[2],
                                             1'b1, 1'b1);
      res_col[SLOT_U1] <= b_x - CW'(1);
      res_col[SLOT_U2] <= b_x;
      res_col[SLOT_L1] <= b_x - CW'(1);
      res_col[SLOT_L2] <= b_x;
      res_row[SLOT_U1] <= b_y - RW'(1);
      res_row[SLOT_U2] <= b_y - RW'(1);
      res_row[SLOT_L1] <= b_y;
      res_row[SLOT_L2] <= b_y;
    end
  end

  assign results.valid      = res_mask != 4'b0000;
  assign results.magnitude  = res_mag[sel];
  assign results.column     = res_col[sel];
  assign results.row        = res_row[sel];
  assign results.frame_last = sel == SLOT_L2;

`ifndef SYNTH
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    b_valid && !b_adv |=> b_valid && $stable(b_x) && $stable(b_px))
    else $error("stalled pixel stage changed");

  a_last_alone: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.frame_last |-> res_mask == 4'b1000)
    else $error("frame end word offered before other words of its pixel");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    out_accept && $onehot(res_mask) && !b_adv |=> !results.valid)
    else $error("result word repeated after its last word was taken");
`endif

endmodule

`default_nettype wire
